@@ rtl/mwm_pkg.sv @@
// Shared widths, record types and register indexes for the mecanum wheel mixer.
// Used by every module of the block; depends on nothing.
package mwm_pkg;

	localparam int DATA_W     = 16;
	localparam int FRAC_BITS  = 15;
	localparam int SCALE_BITS = 12;
	localparam int SCALE_W    = 16;

	localparam int SPEED_W = DATA_W + 2;
	localparam int MAG_W   = SPEED_W - 1;
	localparam int QUO_W   = FRAC_BITS + 1;
	localparam int NORM_W  = QUO_W + 1;
	localparam int NUM_W   = MAG_W + FRAC_BITS;

	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;
	localparam int NSTAGE     = 2 + DIV_STAGES + 3;

	localparam int TP_W   = NORM_W + SCALE_W + 1;
	localparam int CP_W   = DATA_W + SCALE_W + 1;
	localparam int TGT_W  = TP_W - SCALE_BITS;
	localparam int CUR_W  = CP_W - SCALE_BITS;
	localparam int DIFF_W = TGT_W + 1;
	localparam int PROD_W = DIFF_W + SCALE_W + 1;
	localparam int PROP_W = PROD_W - SCALE_BITS;
	localparam int SUM_W  = PROP_W + 1;

	localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRAC_BITS;

	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SCALE   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_VELOCITY_SCALE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN      = 2'd2;

	localparam logic [SCALE_W-1:0] TARGET_SCALE_RST   = 16'd4096;
	localparam logic [SCALE_W-1:0] VELOCITY_SCALE_RST = 16'd4096;
	localparam logic [SCALE_W-1:0] PROP_GAIN_RST      = 16'd0;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic                      neg;
		logic [MAG_W-1:0]          rem;
		logic [QUO_W-1:0]          nq;
		logic signed [DATA_W-1:0]  vel;
		logic signed [SPEED_W-1:0] raw;
	} lane_t;

	typedef struct packed {
		lane_t [3:0]      lane;
		logic [MAG_W-1:0] mag_max;
		logic             norm;
		logic             cor_en;
	} div_t;

endpackage

@@ rtl/mwm_mix.sv @@
// Mixing stages: four wheel speeds from the drive command, then the largest magnitude.
// Prepares the divider record; depends on mwm_pkg.
module mwm_mix (
	input  logic                clk,
	input  logic [1:0]          en,
	input  mwm_pkg::data_t      cmd_x,
	input  mwm_pkg::data_t      cmd_y,
	input  mwm_pkg::data_t      cmd_rotate,
	input  mwm_pkg::data_t      vel [4],
	input  logic                cor_en,
	output mwm_pkg::div_t       d_s2
);
	import mwm_pkg::*;

	logic signed [SPEED_W-1:0] x, y, r;
	logic signed [SPEED_W-1:0] mix [4];
	logic signed [SPEED_W-1:0] speed_s1 [4];
	data_t                     vel_s1 [4];
	logic                      cor_en_s1;
	logic [MAG_W-1:0]          mag [4];
	logic [MAG_W-1:0]          m01, m23, mmax;
	logic [NUM_W-1:0]          num [4];
	div_t                      d_nxt;

	assign x = SPEED_W'(cmd_x);
	assign y = SPEED_W'(cmd_y);
	assign r = SPEED_W'(cmd_rotate);

	assign mix[0] = x + y - r;
	assign mix[1] = x - y - r;
	assign mix[2] = -x + y - r;
	assign mix[3] = -x - y - r;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 4; i++) begin
				speed_s1[i] <= mix[i];
				vel_s1[i]   <= vel[i];
			end
			cor_en_s1 <= cor_en;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i] = speed_s1[i][SPEED_W-1] ? MAG_W'(-speed_s1[i]) : MAG_W'(speed_s1[i]);
			num[i] = {mag[i], {FRAC_BITS{1'b0}}};
		end
		m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
		m23  = (mag[2] > mag[3]) ? mag[2] : mag[3];
		mmax = (m01 > m23) ? m01 : m23;
		for (int i = 0; i < 4; i++) begin
			d_nxt.lane[i].neg = speed_s1[i][SPEED_W-1];
			d_nxt.lane[i].rem = MAG_W'(num[i][NUM_W-1:QUO_W]);
			d_nxt.lane[i].nq  = num[i][QUO_W-1:0];
			d_nxt.lane[i].vel = vel_s1[i];
			d_nxt.lane[i].raw = speed_s1[i];
		end
		d_nxt.mag_max = mmax;
		d_nxt.norm    = mmax > ONE;
		d_nxt.cor_en  = cor_en_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s2 <= d_nxt;
		end
	end

endmodule

@@ rtl/mwm_div_stage.sv @@
// One stage of the restoring divider that scales the wheel speeds by the largest magnitude.
// Resolves four quotient bits for all four wheels; depends on mwm_pkg.
module mwm_div_stage (
	input  logic          clk,
	input  logic          en,
	input  mwm_pkg::div_t d_in,
	output mwm_pkg::div_t d_sk
);
	import mwm_pkg::*;

	div_t           d_nxt;
	logic [MAG_W:0] t;
	logic           ge;

	always_comb begin
		d_nxt = d_in;
		t     = '0;
		ge    = 1'b0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				t  = {d_nxt.lane[i].rem, d_nxt.lane[i].nq[QUO_W-1]};
				ge = t >= {1'b0, d_in.mag_max};
				d_nxt.lane[i].rem = ge ? MAG_W'(t - {1'b0, d_in.mag_max}) : MAG_W'(t);
				d_nxt.lane[i].nq  = {d_nxt.lane[i].nq[QUO_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_sk <= d_nxt;
		end
	end

endmodule

@@ rtl/mwm_correct.sv @@
// Correction stages: target and measured speed products, proportional term, saturation.
// Takes the divider record and the scale registers; depends on mwm_pkg.
module mwm_correct (
	input  logic                         clk,
	input  logic [2:0]                   en,
	input  mwm_pkg::div_t                d_in,
	input  logic [mwm_pkg::SCALE_W-1:0]  target_scale,
	input  logic [mwm_pkg::SCALE_W-1:0]  velocity_scale,
	input  logic [mwm_pkg::SCALE_W-1:0]  prop_gain,
	output mwm_pkg::data_t               drive [4],
	output logic                         clipped
);
	import mwm_pkg::*;

	localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(32768);

	logic signed [SCALE_W:0]  ts, vs, gs;
	logic signed [NORM_W-1:0] qv [4];
	logic signed [NORM_W-1:0] spd [4];
	logic signed [TP_W-1:0]   tp [4];
	logic signed [CP_W-1:0]   cp [4];

	logic signed [TGT_W-1:0]  target_s7 [4];
	logic signed [CUR_W-1:0]  cur_s7 [4];
	logic signed [NORM_W-1:0] speed_s7 [4];
	logic                     cor_en_s7;

	logic signed [DIFF_W-1:0] diff [4];
	logic signed [PROD_W-1:0] prod [4];
	logic signed [TGT_W-1:0]  target_s8 [4];
	logic signed [PROP_W-1:0] prop_s8 [4];
	logic signed [NORM_W-1:0] speed_s8 [4];
	logic                     cor_en_s8;

	logic signed [SUM_W-1:0]  val [4];
	data_t                    sat [4];
	logic [3:0]               clip;

	assign ts = $signed({1'b0, target_scale});
	assign vs = $signed({1'b0, velocity_scale});
	assign gs = $signed({1'b0, prop_gain});

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qv[i]  = d_in.lane[i].neg ? -$signed({1'b0, d_in.lane[i].nq})
			                          : $signed({1'b0, d_in.lane[i].nq});
			spd[i] = d_in.norm ? qv[i] : $signed(d_in.lane[i].raw[NORM_W-1:0]);
			tp[i]  = spd[i] * ts;
			cp[i]  = $signed(d_in.lane[i].vel) * vs;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 4; i++) begin
				target_s7[i] <= TGT_W'(tp[i] >>> SCALE_BITS);
				cur_s7[i]    <= CUR_W'(cp[i] >>> SCALE_BITS);
				speed_s7[i]  <= spd[i];
			end
			cor_en_s7 <= d_in.cor_en;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			diff[i] = DIFF_W'(target_s7[i]) - DIFF_W'(cur_s7[i]);
			prod[i] = diff[i] * gs;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 4; i++) begin
				target_s8[i] <= target_s7[i];
				prop_s8[i]   <= PROP_W'(prod[i] >>> SCALE_BITS);
				speed_s8[i]  <= speed_s7[i];
			end
			cor_en_s8 <= cor_en_s7;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			val[i] = cor_en_s8 ? SUM_W'(target_s8[i]) + SUM_W'(prop_s8[i])
			                   : SUM_W'(speed_s8[i]);
			if (val[i] > OUT_MAX) begin
				sat[i]  = DATA_W'(OUT_MAX);
				clip[i] = 1'b1;
			end else if (val[i] < OUT_MIN) begin
				sat[i]  = DATA_W'(OUT_MIN);
				clip[i] = 1'b1;
			end else begin
				sat[i]  = DATA_W'(val[i]);
				clip[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 4; i++) begin
				drive[i] <= sat[i];
			end
			clipped <= |clip;
		end
	end

endmodule

@@ rtl/mecanum_wheel_mixer.sv @@
// Top level of the mecanum wheel mixer: stream ports, scale registers and pipeline control.
// Instantiates mwm_mix, mwm_div_stage and mwm_correct; depends on mwm_pkg.
//
// The mixer takes one drive request per clock unless the pipeline is full and the output waits,
// and returns one wheel request per accepted request, in order. The depth is set by the
// normalizing divider, which resolves four quotient bits per stage over four stages, between
// two mixing stages and three correction stages: the target and measured products, the
// proportional product, and the saturation. Every stage has its own valid bit and advances
// when the stage after it is free, so bubbles are squeezed out while the output waits. The
// scale registers are read by the pipeline directly and must be written only while no request
// is in flight.
module mecanum_wheel_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// cmd_x, cmd_y, cmd_rotate, vel_front_left, vel_back_left, vel_front_right, vel_back_right
	input  logic [7*mwm_pkg::DATA_W-1:0]       s_tdata,
	// correct_enable
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// drive_front_left, drive_back_left, drive_front_right, drive_back_right
	output logic [4*mwm_pkg::DATA_W-1:0]       m_tdata,
	// clipped
	output logic                               m_tuser,
	input  logic                               cfg_we,
	input  logic [mwm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mwm_pkg::SCALE_W-1:0]        cfg_wdata
);
	import mwm_pkg::*;

	logic [SCALE_W-1:0] target_scale_q, velocity_scale_q, prop_gain_q;
	logic [NSTAGE-1:0]  valid_q;
	logic [NSTAGE-1:0]  rdy;
	data_t              vel [4];
	data_t              drive [4];
	div_t               d_st [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_scale_q   <= TARGET_SCALE_RST;
			velocity_scale_q <= VELOCITY_SCALE_RST;
			prop_gain_q      <= PROP_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_TARGET_SCALE:   target_scale_q   <= cfg_wdata;
				REG_VELOCITY_SCALE: velocity_scale_q <= cfg_wdata;
				REG_PROP_GAIN:      prop_gain_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		rdy[NSTAGE-1] = !valid_q[NSTAGE-1] || m_tready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = valid_q[NSTAGE-1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			vel[i] = s_tdata[(3+i)*DATA_W +: DATA_W];
		end
	end

	mwm_mix u_mix (
		.clk        (clk),
		.en         (rdy[1:0]),
		.cmd_x      (s_tdata[0 +: DATA_W]),
		.cmd_y      (s_tdata[DATA_W +: DATA_W]),
		.cmd_rotate (s_tdata[2*DATA_W +: DATA_W]),
		.vel        (vel),
		.cor_en     (s_tuser),
		.d_s2       (d_st[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		mwm_div_stage u_div (
			.clk  (clk),
			.en   (rdy[2+g]),
			.d_in (d_st[g]),
			.d_sk (d_st[g+1])
		);
	end

	mwm_correct u_correct (
		.clk            (clk),
		.en             (rdy[NSTAGE-1 -: 3]),
		.d_in           (d_st[DIV_STAGES]),
		.target_scale   (target_scale_q),
		.velocity_scale (velocity_scale_q),
		.prop_gain      (prop_gain_q),
		.drive          (drive),
		.clipped        (m_tuser)
	);

	assign m_tdata = {drive[3], drive[2], drive[1], drive[0]};

`ifndef SYNTHESIS
	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[NSTAGE-1] && !m_tready && !valid_q[0] |-> s_tready)
		else $error("input stalled although the first stage is empty");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[1+DIV_STAGES] && d_st[DIV_STAGES].norm |->
			d_st[DIV_STAGES].lane[0].nq <= QUO_W'(ONE) &&
			d_st[DIV_STAGES].lane[1].nq <= QUO_W'(ONE) &&
			d_st[DIV_STAGES].lane[2].nq <= QUO_W'(ONE) &&
			d_st[DIV_STAGES].lane[3].nq <= QUO_W'(ONE))
		else $error("normalized wheel speed exceeds full scale");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[1+DIV_STAGES] && d_st[DIV_STAGES].norm |->
			d_st[DIV_STAGES].lane[0].rem < d_st[DIV_STAGES].mag_max &&
			d_st[DIV_STAGES].lane[1].rem < d_st[DIV_STAGES].mag_max &&
			d_st[DIV_STAGES].lane[2].rem < d_st[DIV_STAGES].mag_max &&
			d_st[DIV_STAGES].lane[3].rem < d_st[DIV_STAGES].mag_max)
		else $error("divider remainder not below the divisor");
`endif

endmodule
